// ===== hdl/mt_pkg.sv =====
package mt_pkg;

	localparam int WORD_W = 32;

	// Default geometry of the generator.
	localparam int DEF_STATE_LEN     = 624;
	localparam int DEF_MIDDLE_OFFSET = 397;

	localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fff_ffff;

	// Function codes of an input transaction.
	localparam logic FUNC_SEED = 1'b0;
	localparam logic FUNC_NEXT = 1'b1;

	// Output tempering of one state word.
	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
		logic [WORD_W-1:0] y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ===== hdl/mt_ram.sv =====
module mt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mt19937_generator.sv =====
// A next transaction on a seeded generator with words left runs OUT_RD and OUT_TMP and raises
// its result strobe as it returns to idle; a new transaction is accepted only once busy is low.
// When the state is exhausted, the in-place twist of the whole state runs first.
// A seed transaction keeps busy high while it fills the state and gives no result.
// A next before any seed gives its result in the cycle after acceptance; the receiver cannot stall.
// Reset (arst_n low) makes the generator idle and unseeded; the state memory is not cleared.
module mt19937_generator #(
	parameter int STATE_LEN     = mt_pkg::DEF_STATE_LEN,
	parameter int MIDDLE_OFFSET = mt_pkg::DEF_MIDDLE_OFFSET
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [mt_pkg::WORD_W-1:0] seed,
	output logic                      done,
	output logic [mt_pkg::WORD_W-1:0] word,
	output logic                      unseeded
);

	import mt_pkg::*;

	// Address width of the state memory, and the width of the read index, which must
	// also be able to hold STATE_LEN itself (the exhausted mark).
	localparam int AddrW = $clog2(STATE_LEN);
	localparam int IdxW  = $clog2(STATE_LEN + 1);

	// The sequencer. Seeding runs SEED_W0 once and then alternates SEED_MUL and
	// SEED_WR, one state word per pair. Twisting reads word 0 (TW_HEAD, TW_NXT) and
	// then alternates TW_MID and TW_WR, one word per pair. Delivery of a word is
	// OUT_RD (memory read) followed by OUT_TMP (tempering into the output register).
	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_SEED_W0  = 10'b00_0000_0010,
		ST_SEED_MUL = 10'b00_0000_0100,
		ST_SEED_WR  = 10'b00_0000_1000,
		ST_TW_HEAD  = 10'b00_0001_0000,
		ST_TW_NXT   = 10'b00_0010_0000,
		ST_TW_MID   = 10'b00_0100_0000,
		ST_TW_WR    = 10'b00_1000_0000,
		ST_OUT_RD   = 10'b01_0000_0000,
		ST_OUT_TMP  = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Control registers.
	logic            seeded_q;
	logic [IdxW-1:0] rd_idx_q;
	logic            done_q;

	// Working registers: the word index of the seed fill or the twist, and the
	// index of the middle word used by the twist.
	logic [AddrW-1:0] idx_q;
	logic [AddrW-1:0] mid_q;

	// Datapath registers. prev_q is the last word written by the seed fill and
	// prod_s1 the registered product of the recurrence. cur_q and nxt_q hold
	// words i and i+1 during the twist, so each twisted word needs only the
	// read of word i+1 and of the middle word.
	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] prod_s1;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] nxt_q;
	logic [WORD_W-1:0] word_q;
	logic              unseeded_q;

	// Memory port signals.
	logic              ram_we;
	logic [AddrW-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AddrW-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic              accept;
	logic [WORD_W-1:0] seed_word;
	logic [WORD_W-1:0] tw_y;
	logic [WORD_W-1:0] tw_word;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// The seeding recurrence: the product is registered, the index is added
	// on the way into memory.
	assign seed_word = prod_s1 + WORD_W'(idx_q);

	// One twist step. In rdata during TW_WR lies the middle word, which for the
	// upper part of the state has already been twisted in this pass, as required.
	assign tw_y    = (cur_q & UPPER_MASK) | (nxt_q & LOWER_MASK);
	assign tw_word = ram_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MATRIX : '0);

	// Memory access per state. A write never meets a read of the same entry in
	// one cycle: the twist writes word i while it reads word i+2, or word 0 at the wrap.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = seed_word;
		ram_raddr = idx_q;
		case (state_q)
			ST_SEED_W0: begin
				ram_we    = 1'b1;
				ram_wdata = prev_q;
			end
			ST_SEED_WR: begin
				ram_we    = 1'b1;
				ram_wdata = seed_word;
			end
			ST_TW_HEAD: begin
				ram_raddr = '0;
			end
			ST_TW_NXT: begin
				ram_raddr = idx_q + AddrW'(1);
			end
			ST_TW_MID: begin
				ram_raddr = mid_q;
			end
			ST_TW_WR: begin
				ram_we    = 1'b1;
				ram_wdata = tw_word;
				ram_raddr = (idx_q == AddrW'(STATE_LEN - 2)) ? '0 : idx_q + AddrW'(2);
			end
			ST_OUT_RD: begin
				ram_raddr = rd_idx_q[AddrW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	mt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STATE_LEN)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			seeded_q <= 1'b0;
			rd_idx_q <= IdxW'(STATE_LEN);
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == FUNC_SEED) begin
							state_q <= ST_SEED_W0;
						end else if (!seeded_q) begin
							// Next before any seed: the result goes out straight from idle, with no memory read.
							done_q <= 1'b1;
						end else if (rd_idx_q >= IdxW'(STATE_LEN)) begin
							state_q <= ST_TW_HEAD;
						end else begin
							state_q <= ST_OUT_RD;
						end
					end
				end
				ST_SEED_W0: begin
					state_q <= ST_SEED_MUL;
				end
				ST_SEED_MUL: begin
					state_q <= ST_SEED_WR;
				end
				ST_SEED_WR: begin
					if (idx_q == AddrW'(STATE_LEN - 1)) begin
						state_q  <= ST_IDLE;
						seeded_q <= 1'b1;
						rd_idx_q <= IdxW'(STATE_LEN);
					end else begin
						state_q <= ST_SEED_MUL;
					end
				end
				ST_TW_HEAD: begin
					state_q <= ST_TW_NXT;
				end
				ST_TW_NXT: begin
					state_q <= ST_TW_MID;
				end
				ST_TW_MID: begin
					state_q <= ST_TW_WR;
				end
				ST_TW_WR: begin
					if (idx_q == AddrW'(STATE_LEN - 1)) begin
						state_q  <= ST_OUT_RD;
						rd_idx_q <= '0;
					end else begin
						state_q <= ST_TW_MID;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_TMP;
				end
				ST_OUT_TMP: begin
					state_q  <= ST_IDLE;
					done_q   <= 1'b1;
					rd_idx_q <= rd_idx_q + IdxW'(1);
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					prev_q     <= seed;
					idx_q      <= '0;
					word_q     <= '0;
					unseeded_q <= 1'b1;
				end
			end
			ST_SEED_MUL: begin
				prod_s1 <= WORD_W'(INIT_MULT * (prev_q ^ (prev_q >> 30)));
				idx_q   <= idx_q + AddrW'(1);
			end
			ST_SEED_WR: begin
				prev_q <= seed_word;
			end
			ST_TW_HEAD: begin
				idx_q <= '0;
				mid_q <= AddrW'(MIDDLE_OFFSET);
			end
			ST_TW_NXT: begin
				cur_q <= ram_rdata;
			end
			ST_TW_MID: begin
				nxt_q <= ram_rdata;
			end
			ST_TW_WR: begin
				cur_q <= nxt_q;
				idx_q <= idx_q + AddrW'(1);
				mid_q <= (mid_q == AddrW'(STATE_LEN - 1)) ? '0 : mid_q + AddrW'(1);
			end
			ST_OUT_TMP: begin
				word_q     <= temper(ram_rdata);
				unseeded_q <= 1'b0;
			end
			default: begin
				prev_q <= prev_q;
			end
		endcase
	end

	assign done     = done_q;
	assign word     = word_q;
	assign unseeded = unseeded_q;

	// A result strobe is only ever raised while the sequencer is in idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while the sequencer is busy");

	// The read index never passes the exhausted mark.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= IdxW'(STATE_LEN))
		else $error("read index beyond the state length");

	// The last twist step leads straight to delivery of word zero.
	a_twist_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TW_WR && idx_q == AddrW'(STATE_LEN - 1))
		|=> (state_q == ST_OUT_RD && rd_idx_q == '0))
		else $error("twist did not hand over to delivery of word zero");

	// A seeded result comes from the tempering stage.
	a_seeded_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !unseeded_q) |-> ($past(state_q) == ST_OUT_TMP))
		else $error("seeded result without a memory read");

endmodule
